### hdl/trapezoid_waveform_generator_core_assert.svh
// Assertion macros used by the checker file of the trapezoid generator.
`ifndef TRAPEZOID_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define TRAPEZOID_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TWG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trapezoid generator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trapezoid generator: next-cycle check failed");

`endif

### hdl/twg_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid generator package
// Widths, constants and register indexes shared by the generator files.
// ----------------------------------------------------------------------------
package twg_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int QBITS      = FRAC_BITS + 1;   // quotient bits of the scaler
    localparam int TIME_W     = 32;
    localparam int PCT_W      = 14;
    localparam int AMP_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int ABS_W      = AMP_W + 1;
    localparam int RISE_W     = 46;              // holds 10000 * (2^32 - 1)
    localparam int N20_W      = 47;              // holds 20000 * (2^32 - 1)
    localparam int X_W        = RISE_W + QBITS;
    localparam int CELL_W     = RISE_W;
    localparam int DVD_W      = 32;
    localparam int MOD_STAGES = TIME_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(10000);
    localparam logic [N20_W-1:0] SCALE20  = N20_W'(20000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PERIOD  = 2'd0,
        CFG_PERCENT = 2'd1,
        CFG_AMP     = 2'd2,
        CFG_AC_MODE = 2'd3
    } t_cfg_idx;

endpackage

### hdl/twg_cell.sv
// ----------------------------------------------------------------------------
// Trapezoid generator division cell
// One restoring step: shifts the next dividend bit into the remainder,
// subtracts the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module twg_cell (
    input  logic                             i_clk,
    input  logic                             i_ce,
    input  logic [twg_pkg::CELL_W-1:0]       i_div,
    input  logic [twg_pkg::CELL_W-1:0]       i_rem,
    input  logic [twg_pkg::DVD_W-1:0]        i_dvd,
    output logic [twg_pkg::CELL_W-1:0]       o_rem,
    output logic [twg_pkg::DVD_W-1:0]        o_dvd
);

    logic [twg_pkg::CELL_W:0]   w_trial;
    logic [twg_pkg::CELL_W:0]   w_diff;
    logic                       w_ge;
    logic [twg_pkg::CELL_W-1:0] r_rem;
    logic [twg_pkg::DVD_W-1:0]  r_dvd;

    assign w_trial = {i_rem, i_dvd[twg_pkg::DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = (w_trial >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem <= w_ge ? w_diff[twg_pkg::CELL_W-1:0] : w_trial[twg_pkg::CELL_W-1:0];
            r_dvd <= {i_dvd[twg_pkg::DVD_W-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_dvd = r_dvd;

endmodule

### hdl/trapezoid_waveform_generator_core.sv
// ----------------------------------------------------------------------------
// Trapezoid waveform generator core
// Evaluates one sample of a periodic trapezoid for each time word.
// ----------------------------------------------------------------------------
// The core takes one time word per clock while its skid slot is empty and
// returns one sample word per clock while the output is taken; every word
// passes 32 remainder cells, three multiply and compare stages, 15 scaling
// cells and the output register. The depth is set by the two rows of
// remainder cells, which find the phase one bit a cell, and the row of
// scaling cells, which find the ramp value one bit a cell. A two-word
// output buffer lets a new time word in while a finished sample waits.
// Configuration writes act through the configuration and derived registers.
module trapezoid_waveform_generator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [twg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [twg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,   // time_ms
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // sample_q14
    output logic                               m_axis_tuser    // invalid
);

    localparam int MS = twg_pkg::MOD_STAGES;
    localparam int QB = twg_pkg::QBITS;

    // Configuration registers.
    logic [twg_pkg::TIME_W-1:0] r_period;
    logic [twg_pkg::PCT_W-1:0]  r_pct;
    logic [twg_pkg::AMP_W-1:0]  r_amp;
    logic                       r_ac;

    // Values derived from the configuration.
    logic [twg_pkg::TIME_W-1:0] w_inner;
    logic [twg_pkg::ABS_W-1:0]  w_amp_x;
    logic [twg_pkg::ABS_W-1:0]  w_abs;
    logic [twg_pkg::PCT_W-1:0]  w_pct_diff;
    logic [twg_pkg::RISE_W-1:0] r_rise20;
    logic [twg_pkg::N20_W-1:0]  r_full;
    logic [twg_pkg::N20_W-1:0]  r_flat_hi;
    logic [QB-1:0]              r_mag;
    logic                       r_amp_neg;
    logic                       r_invalid;

    // Pipeline control.
    logic                       w_ce;
    logic [MS-1:0]              r_vld_mod;
    logic                       r_m1_vld, r_m2_vld, r_m3_vld;
    logic [QB-1:0]              r_vld_div;

    // Cell rows.
    logic [twg_pkg::CELL_W-1:0] w_rem_a [MS+1];
    logic [twg_pkg::DVD_W-1:0]  w_dvd_a [MS+1];
    logic [twg_pkg::CELL_W-1:0] w_rem_b [MS+1];
    logic [twg_pkg::DVD_W-1:0]  w_dvd_b [MS+1];
    logic [twg_pkg::CELL_W-1:0] w_rem_d [QB+1];
    logic [twg_pkg::DVD_W-1:0]  w_dvd_d [QB+1];

    // Middle stages.
    logic [twg_pkg::N20_W-1:0]  r_n20;
    logic                       r_m1_neg;
    logic [twg_pkg::RISE_W-1:0] r_num;
    logic                       r_m2_neg, r_m2_flat;
    logic [twg_pkg::X_W-1:0]    r_x;
    logic                       r_m3_neg, r_m3_flat;
    logic [QB-1:0]              r_neg_d, r_flat_d;
    logic                       w_lt, w_le;

    // End of pipeline and output buffer.
    logic [QB-1:0]                w_q;
    logic [QB-1:0]                w_v;
    logic [twg_pkg::SAMPLE_W-1:0] w_v16;
    logic [twg_pkg::SAMPLE_W-1:0] w_sample;
    logic                         w_end_vld;
    logic                         r_ov, r_sv;
    logic [twg_pkg::SAMPLE_W-1:0] r_od, r_sd;
    logic                         r_ou, r_su;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= twg_pkg::TIME_W'(1000);
            r_pct    <= twg_pkg::PCT_W'(5000);
            r_amp    <= twg_pkg::AMP_W'(16384);
            r_ac     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (twg_pkg::t_cfg_idx'(i_cfg_addr))
                twg_pkg::CFG_PERIOD:  r_period <= i_cfg_wdata[twg_pkg::TIME_W-1:0];
                twg_pkg::CFG_PERCENT: r_pct    <= i_cfg_wdata[twg_pkg::PCT_W-1:0];
                twg_pkg::CFG_AMP:     r_amp    <= i_cfg_wdata[twg_pkg::AMP_W-1:0];
                twg_pkg::CFG_AC_MODE: r_ac     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_inner    = r_ac ? (r_period >> 1) : r_period;
    assign w_amp_x    = {r_amp[twg_pkg::AMP_W-1], r_amp};
    assign w_abs      = r_amp[twg_pkg::AMP_W-1] ? (twg_pkg::ABS_W'(0) - w_amp_x) : w_amp_x;
    assign w_pct_diff = twg_pkg::PCT_FULL - r_pct;

    always_ff @(posedge i_clk) begin
        r_rise20  <= twg_pkg::RISE_W'(w_pct_diff) * twg_pkg::RISE_W'(w_inner);
        r_full    <= twg_pkg::N20_W'(w_inner) * twg_pkg::SCALE20;
        r_flat_hi <= r_full - twg_pkg::N20_W'(r_rise20);
        r_mag     <= QB'(w_abs);
        r_amp_neg <= r_amp[twg_pkg::AMP_W-1];
        r_invalid <= (r_pct > twg_pkg::PCT_FULL)
                  || (64'(w_abs) > (64'd1 << twg_pkg::FRAC_BITS))
                  || (w_inner == '0);
    end

    // ------------------------------------------------------------------
    // Phase: two rows of remainder cells, by the period and the inner period
    // ------------------------------------------------------------------
    assign w_ce          = !r_sv;
    assign s_axis_tready = w_ce;

    assign w_rem_a[0] = '0;
    assign w_dvd_a[0] = s_axis_tdata;
    assign w_rem_b[0] = '0;
    assign w_dvd_b[0] = s_axis_tdata;

    for (genvar g = 0; g < MS; g++) begin : g_mod
        twg_cell u_cell_a (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_div (twg_pkg::CELL_W'(r_period)),
            .i_rem (w_rem_a[g]),
            .i_dvd (w_dvd_a[g]),
            .o_rem (w_rem_a[g+1]),
            .o_dvd (w_dvd_a[g+1])
        );
        twg_cell u_cell_b (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_div (twg_pkg::CELL_W'(w_inner)),
            .i_rem (w_rem_b[g]),
            .i_dvd (w_dvd_b[g]),
            .o_rem (w_rem_b[g+1]),
            .o_dvd (w_dvd_b[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Region select and scaling product
    // ------------------------------------------------------------------
    assign w_lt = (r_n20 < twg_pkg::N20_W'(r_rise20));
    assign w_le = (r_n20 <= r_flat_hi);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_n20    <= twg_pkg::N20_W'(w_rem_b[MS][twg_pkg::TIME_W-1:0]) * twg_pkg::SCALE20;
            // In alternating mode the second half of the full period is negated.
            r_m1_neg <= r_amp_neg ^ (r_ac
                        && (w_rem_a[MS][twg_pkg::TIME_W-1:0] >= (r_period >> 1)));

            r_num     <= w_lt ? twg_pkg::RISE_W'(r_n20) : twg_pkg::RISE_W'(r_full - r_n20);
            r_m2_flat <= !w_lt && w_le;
            r_m2_neg  <= r_m1_neg;

            r_x       <= twg_pkg::X_W'(r_mag) * twg_pkg::X_W'(r_num);
            r_m3_flat <= r_m2_flat;
            r_m3_neg  <= r_m2_neg;

            r_neg_d   <= {r_neg_d[QB-2:0], r_m3_neg};
            r_flat_d  <= {r_flat_d[QB-2:0], r_m3_flat};
        end
    end

    // ------------------------------------------------------------------
    // Ramp value: one row of scaling cells; the quotient stays below 2^QBITS
    // ------------------------------------------------------------------
    assign w_rem_d[0] = r_x[twg_pkg::X_W-1:QB];
    assign w_dvd_d[0] = twg_pkg::DVD_W'(r_x[QB-1:0]) << (twg_pkg::DVD_W - QB);

    for (genvar g = 0; g < QB; g++) begin : g_div
        twg_cell u_cell_d (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_div (twg_pkg::CELL_W'(r_rise20)),
            .i_rem (w_rem_d[g]),
            .i_dvd (w_dvd_d[g]),
            .o_rem (w_rem_d[g+1]),
            .o_dvd (w_dvd_d[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_mod <= '0;
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_m3_vld  <= 1'b0;
            r_vld_div <= '0;
        end else if (w_ce) begin
            r_vld_mod <= {r_vld_mod[MS-2:0], s_axis_tvalid};
            r_m1_vld  <= r_vld_mod[MS-1];
            r_m2_vld  <= r_m1_vld;
            r_m3_vld  <= r_m2_vld;
            r_vld_div <= {r_vld_div[QB-2:0], r_m3_vld};
        end
    end

    // ------------------------------------------------------------------
    // Sample and output buffer
    // ------------------------------------------------------------------
    assign w_q       = w_dvd_d[QB][QB-1:0];
    assign w_v       = r_flat_d[QB-1] ? r_mag : w_q;
    assign w_v16     = twg_pkg::SAMPLE_W'(w_v);
    assign w_sample  = r_invalid ? '0 : (r_neg_d[QB-1] ? (twg_pkg::SAMPLE_W'(0) - w_v16) : w_v16);
    assign w_end_vld = r_vld_div[QB-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (m_axis_tready) begin
                r_od <= r_sd;
                r_ou <= r_su;
                r_sv <= 1'b0;
            end
        end else if (!r_ov || m_axis_tready) begin
            r_ov <= w_end_vld;
            r_od <= w_sample;
            r_ou <= r_invalid;
        end else if (w_end_vld) begin
            // Output word still waiting: park the new word in the skid slot.
            r_sv <= 1'b1;
            r_sd <= w_sample;
            r_su <= r_invalid;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ou;

endmodule

### hdl/twg_checker.sv
// ----------------------------------------------------------------------------
// Trapezoid generator port checker
// Watches the output stream port of the generator core over time.
// ----------------------------------------------------------------------------
`include "trapezoid_waveform_generator_core_assert.svh"

module twg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [15:0]                    m_axis_tdata,
    input logic                           m_axis_tuser
);

    `TWG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TWG_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `TWG_ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0)
    `TWG_ASSERT_IMPLY(a_sample_range, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, ($signed(m_axis_tdata) <= 16'sd16384) && ($signed(m_axis_tdata) >= -16'sd16384))

endmodule

bind trapezoid_waveform_generator_core twg_checker u_twg_checker (.*);

### dv/trapezoid_waveform_generator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trapezoid waveform generator core test
// Drives time words through the core under several register settings and
// compares each sample word and invalid flag against an exact integer model
// of the trapezoid, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module trapezoid_waveform_generator_core_test;

    typedef struct packed {
        logic [15:0] sample;
        logic        invalid;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [twg_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [twg_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Shadow copy of the core's registers.
    logic [31:0] period_reg;
    logic [13:0] percent_reg;
    logic [15:0] amp_reg;
    logic        ac_reg;

    t_sample     pending_samples[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          stall_enable = 1'b1;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 51;

    trapezoid_waveform_generator_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_sample trapezoid_sample(input logic [31:0] t);
        t_sample     res;
        logic [31:0] inner;
        logic [63:0] mag, n20, full, rise20, v;
        logic signed [16:0] amp;
        logic        neg;
        amp = $signed(amp_reg);
        inner = ac_reg ? period_reg / 2 : period_reg;
        mag = (amp < 0) ? 64'(-amp) : 64'(amp);
        res.sample = '0;
        res.invalid = 1'b1;
        if (percent_reg > 14'd10000 || mag > 64'd16384 || inner == 0)
            return res;
        res.invalid = 1'b0;
        neg = amp < 0;
        if (ac_reg && (t % period_reg) >= period_reg / 2)
            neg = !neg;
        n20 = 64'(t % inner) * 64'd20000;
        full = 64'(inner) * 64'd20000;
        rise20 = 64'(14'd10000 - percent_reg) * 64'(inner);
        if (n20 < rise20)
            v = (mag * n20) / rise20;
        else if (n20 <= full - rise20)
            v = mag;
        else
            v = (mag * (full - n20)) / rise20;
        res.sample = neg ? 16'(-v) : v[15:0];
        return res;
    endfunction

    // The write lands at the next edge; the shadow follows at once since the
    // core is idle whenever this is called.
    task automatic write_reg(input twg_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            twg_pkg::CFG_PERIOD:  period_reg  = val;
            twg_pkg::CFG_PERCENT: percent_reg = val[13:0];
            twg_pkg::CFG_AMP:     amp_reg     = val[15:0];
            twg_pkg::CFG_AC_MODE: ac_reg      = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] per, input logic [13:0] pct,
                              input logic [15:0] amp, input logic ac);
        write_reg(twg_pkg::CFG_PERIOD, per);
        write_reg(twg_pkg::CFG_PERCENT, 32'(pct));
        write_reg(twg_pkg::CFG_AMP, 32'(amp));
        write_reg(twg_pkg::CFG_AC_MODE, 32'(ac));
    endtask

    // Sends one time word; random gaps come from the burst counter. Within a
    // burst tvalid stays high from one word to the next.
    int burst_left = 0;
    task automatic send_time(input logic [31:0] t);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        pending_samples.push_back(trapezoid_sample(t));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_samples.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_enable)
            m_axis_tready <= ($urandom_range(0, 9) < 7);
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected sample word %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_axis_tdata !== want.sample) begin
                    $error("sample_q14: expected %h, got %h", want.sample, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.invalid) begin
                    $error("invalid: expected %b, got %b", want.invalid, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("trapezoid_waveform_generator_core_test: done, errors");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        logic [31:0] edges [11] = '{0, 1, 249, 250, 499, 500, 750, 751, 999, 1000,
                                    32'hFFFF_FFFF};
        foreach (edges[i]) send_time(edges[i]);
        drain();
    endtask

    task automatic test_extremes();
        set_config(32'hFFFF_FFFF, 14'd0, 16'h4000, 1'b0);
        send_time(32'h7FFF_FFFF);
        send_time(32'hFFFF_FFFE);
        send_time(32'h0000_0001);
        drain();
        set_config(32'd7, 14'd10000, 16'hC000, 1'b1);      // zero rise, odd AC
        for (int i = 0; i < 8; i++) send_time(i);
        drain();
        set_config(32'd1, 14'd5000, 16'h0100, 1'b1);        // inner period zero
        send_time(32'd5);
        drain();
        set_config(32'd0, 14'd5000, 16'h0100, 1'b0);        // period zero
        send_time(32'd5);
        drain();
        set_config(32'd100, 14'd10001, 16'h0100, 1'b0);     // percent too high
        send_time(32'd5);
        drain();
        set_config(32'd100, 14'h3FFF, 16'h0100, 1'b0);
        send_time(32'd5);
        drain();
        set_config(32'd100, 14'd2000, 16'h4001, 1'b0);      // amplitude too big
        send_time(32'd5);
        drain();
        set_config(32'd100, 14'd2000, 16'h8000, 1'b0);
        send_time(32'd5);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int phase = 0; phase < 10; phase++) begin
            logic [31:0] per;
            logic [13:0] pct;
            logic [15:0] amp;
            per = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(2, 3000);
            pct = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000));
            amp = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                  : 16'($signed($urandom_range(0, 32768)) - 16384);
            set_config(per, pct, amp, 1'($urandom));
            stall_enable = (phase % 3) != 2;
            for (int i = 0; i < count / 10; i++)
                send_time(($urandom_range(0, 1) == 0) ? $urandom
                          : $urandom_range(0, 2 * (per > 10000 ? 10000 : per)));
            drain();
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        period_reg  = 32'd1000;
        percent_reg = 14'd5000;
        amp_reg     = 16'd16384;
        ac_reg      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extremes();
        test_random(520);
        if (error_count == 0)
            $display("trapezoid_waveform_generator_core_test: done, clean");
        else
            $display("trapezoid_waveform_generator_core_test: done, errors");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/twg_pkg.sv
hdl/twg_cell.sv
hdl/trapezoid_waveform_generator_core.sv
hdl/twg_checker.sv
dv/trapezoid_waveform_generator_core_test.sv
